// ===== rtl/lcrt_pkg.sv =====
package lcrt_pkg;

	localparam int CAPACITY    = 1024;   // power of two
	localparam int PROBE_LIMIT = 8;

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int PRB_W  = $clog2(PROBE_LIMIT + 1);
	localparam int KEY_W  = 32;
	localparam int LEN_W  = 11;
	localparam int SEEN_W = KEY_W + 1;
	localparam int EP_W   = 2 * KEY_W + 1;

	localparam logic [KEY_W-1:0] HASH_MUL = 32'h9E37_79B1;
	localparam logic [KEY_W-1:0] I32_MIN  = 32'h8000_0000;
	localparam logic [KEY_W-1:0] I32_MAX  = 32'h7FFF_FFFF;
	localparam logic [LEN_W-1:0] LEN_MAX  = 11'd2047;

	typedef logic [IDX_W-1:0] slot_t;
	typedef logic [KEY_W-1:0] key_t;

endpackage

// ===== rtl/lcrt_ram.sv =====
module lcrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = lcrt_pkg::CAPACITY
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/lcrt_hash.sv =====
module lcrt_hash (
	input  logic           clk,
	input  lcrt_pkg::key_t key,
	output lcrt_pkg::slot_t base
);

	lcrt_pkg::key_t prod_q;
	lcrt_pkg::key_t mix;

	always_ff @(posedge clk) begin
		prod_q <= key * lcrt_pkg::HASH_MUL;
	end

	// fold the high half down, then keep the low index bits
	assign mix  = prod_q ^ (prod_q >> 16);
	assign base = mix[lcrt_pkg::IDX_W-1:0];

endmodule

// ===== rtl/longest_consecutive_run_tracker.sv =====
// Longest consecutive run tracker. Give a request by raising start while busy is low; value and
// last are taken at that edge. Exactly one result follows per request, shown for a single cycle
// with res_strobe high; it cannot be held off, so capture it on that edge. Seen values and run
// endpoints live in two single-read-port hashed memories, and every lookup walks PROBE_LIMIT
// slots one read per cycle. A repeated value or a full seen store ends after the seen-value scan;
// a new value takes up to five scans (seen, left neighbour, right neighbour, two endpoint writes).
// After reset, and after the result of a request marked last, busy stays high for a clearing pass
// that zeroes every slot of both memories.
module longest_consecutive_run_tracker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] value,
	input  logic               last,
	output logic               res_strobe,
	output logic [10:0]        longest_run,
	output logic               overflow,
	output logic               done_res
);

	localparam int IW = lcrt_pkg::IDX_W;
	localparam int PW = lcrt_pkg::PRB_W;
	localparam int KW = lcrt_pkg::KEY_W;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_HASH   = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_EVAL   = 3'd4;
	localparam logic [2:0] S_DECIDE = 3'd5;
	localparam logic [2:0] S_DEL_R  = 3'd6;
	localparam logic [2:0] S_RESULT = 3'd7;

	localparam logic [2:0] PH_SEEN  = 3'd0;
	localparam logic [2:0] PH_LEFT  = 3'd1;
	localparam logic [2:0] PH_RIGHT = 3'd2;
	localparam logic [2:0] PH_PUT_A = 3'd3;
	localparam logic [2:0] PH_PUT_B = 3'd4;

	logic [2:0] state_q, ph_q;
	logic [IW-1:0] clr_q;
	logic [PW-1:0] pi_q, idx_s1;
	logic rv_s1;
	lcrt_pkg::slot_t slot_s1, base, probe_addr;

	lcrt_pkg::key_t v_q, scan_key_q, pa_q, pb_q, lp_q, rp_q, hit_part_q;
	logic last_q, lf_q, rf_q, hit_q, free_q;
	lcrt_pkg::slot_t ls_q, rs_q, hit_slot_q, free_slot_q;
	logic [lcrt_pkg::LEN_W-1:0] best_q;
	logic full_q;

	logic seen_we, ep_we;
	lcrt_pkg::slot_t seen_waddr, ep_waddr;
	logic [lcrt_pkg::SEEN_W-1:0] seen_wdata, seen_rdata;
	logic [lcrt_pkg::EP_W-1:0] ep_wdata, ep_rdata;

	logic rd_valid;
	lcrt_pkg::key_t rd_key;
	logic del_l, del_r;
	lcrt_pkg::key_t lo, hi, diff, put_part;
	logic [lcrt_pkg::LEN_W-1:0] run_len;

	lcrt_hash u_hash (
		.clk  (clk),
		.key  (scan_key_q),
		.base (base)
	);

	lcrt_ram #(.WIDTH(lcrt_pkg::SEEN_W), .DEPTH(lcrt_pkg::CAPACITY)) u_seen (
		.clk   (clk),
		.we    (seen_we),
		.waddr (seen_waddr),
		.wdata (seen_wdata),
		.raddr (probe_addr),
		.rdata (seen_rdata)
	);

	lcrt_ram #(.WIDTH(lcrt_pkg::EP_W), .DEPTH(lcrt_pkg::CAPACITY)) u_ep (
		.clk   (clk),
		.we    (ep_we),
		.waddr (ep_waddr),
		.wdata (ep_wdata),
		.raddr (probe_addr),
		.rdata (ep_rdata)
	);

	assign probe_addr = base + IW'(pi_q);

	assign rd_valid = (ph_q == PH_SEEN) ? seen_rdata[KW] : ep_rdata[2*KW];
	assign rd_key   = (ph_q == PH_SEEN) ? seen_rdata[KW-1:0] : ep_rdata[2*KW-1:KW];

	assign del_l = lf_q && ((v_q - 32'd1) != lp_q);
	assign del_r = rf_q && ((v_q + 32'd1) != rp_q);

	assign lo = lf_q ? lp_q : v_q;
	assign hi = rf_q ? rp_q : v_q;
	assign diff = hi - lo;
	assign run_len = (diff >= 32'd2046) ? lcrt_pkg::LEN_MAX : (diff[lcrt_pkg::LEN_W-1:0] + 11'd1);

	assign put_part = (ph_q == PH_PUT_A) ? pb_q : pa_q;

	always_comb begin
		seen_we    = 1'b0;
		seen_waddr = free_slot_q;
		seen_wdata = {1'b1, v_q};
		ep_we      = 1'b0;
		ep_waddr   = hit_q ? hit_slot_q : free_slot_q;
		ep_wdata   = {1'b1, scan_key_q, put_part};
		unique case (state_q)
			S_CLEAR: begin
				seen_we    = 1'b1;
				seen_waddr = clr_q;
				seen_wdata = '0;
				ep_we      = 1'b1;
				ep_waddr   = clr_q;
				ep_wdata   = '0;
			end
			S_EVAL: begin
				if (ph_q == PH_SEEN && !hit_q && free_q) begin
					seen_we = 1'b1;
				end
				if ((ph_q == PH_PUT_A || ph_q == PH_PUT_B) && (hit_q || free_q)) begin
					ep_we = 1'b1;
				end
			end
			S_DECIDE: begin
				ep_we    = del_l;
				ep_waddr = ls_q;
				ep_wdata = '0;
			end
			S_DEL_R: begin
				ep_we    = del_r;
				ep_waddr = rs_q;
				ep_wdata = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ph_q    <= PH_SEEN;
			clr_q   <= '0;
			pi_q    <= '0;
			rv_s1   <= 1'b0;
			best_q  <= '0;
			full_q  <= 1'b0;
			last_q  <= 1'b0;
			hit_q   <= 1'b0;
			free_q  <= 1'b0;
			lf_q    <= 1'b0;
			rf_q    <= 1'b0;
		end else begin
			rv_s1   <= (state_q == S_SCAN) && (pi_q < PW'(lcrt_pkg::PROBE_LIMIT));
			idx_s1  <= pi_q;
			slot_s1 <= probe_addr;

			// keep the first matching slot and the first free slot in probe order
			if (rv_s1) begin
				if (rd_valid && rd_key == scan_key_q && !hit_q) begin
					hit_q      <= 1'b1;
					hit_slot_q <= slot_s1;
					hit_part_q <= ep_rdata[KW-1:0];
				end
				if (!rd_valid && !free_q) begin
					free_q      <= 1'b1;
					free_slot_q <= slot_s1;
				end
			end

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IW'(lcrt_pkg::CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						v_q        <= value;
						scan_key_q <= value;
						last_q     <= last;
						ph_q       <= PH_SEEN;
						state_q    <= S_HASH;
					end
				end
				S_HASH: begin
					pi_q    <= '0;
					hit_q   <= 1'b0;
					free_q  <= 1'b0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (pi_q < PW'(lcrt_pkg::PROBE_LIMIT)) begin
						pi_q <= pi_q + 1'b1;
					end
					if (rv_s1 && idx_s1 == PW'(lcrt_pkg::PROBE_LIMIT - 1)) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					unique case (ph_q)
						PH_SEEN: begin
							lf_q <= 1'b0;
							rf_q <= 1'b0;
							if (hit_q) begin
								state_q <= S_RESULT;
							end else if (!free_q) begin
								full_q  <= 1'b1;
								state_q <= S_RESULT;
							end else if (v_q != lcrt_pkg::I32_MIN) begin
								scan_key_q <= v_q - 32'd1;
								ph_q       <= PH_LEFT;
								state_q    <= S_HASH;
							end else begin
								scan_key_q <= v_q + 32'd1;
								ph_q       <= PH_RIGHT;
								state_q    <= S_HASH;
							end
						end
						PH_LEFT: begin
							lf_q <= hit_q;
							ls_q <= hit_slot_q;
							lp_q <= hit_part_q;
							if (v_q != lcrt_pkg::I32_MAX) begin
								scan_key_q <= v_q + 32'd1;
								ph_q       <= PH_RIGHT;
								state_q    <= S_HASH;
							end else begin
								state_q <= S_DECIDE;
							end
						end
						PH_RIGHT: begin
							rf_q    <= hit_q;
							rs_q    <= hit_slot_q;
							rp_q    <= hit_part_q;
							state_q <= S_DECIDE;
						end
						PH_PUT_A: begin
							if (!hit_q && !free_q) begin
								full_q <= 1'b1;
							end
							scan_key_q <= pb_q;
							ph_q       <= PH_PUT_B;
							state_q    <= S_HASH;
						end
						default: begin
							if (!hit_q && !free_q) begin
								full_q <= 1'b1;
							end
							state_q <= S_RESULT;
						end
					endcase
				end
				S_DECIDE: begin
					if (run_len > best_q) begin
						best_q <= run_len;
					end
					// a run that grows only upward stores its high end first
					if (!lf_q && rf_q) begin
						pa_q <= hi;
						pb_q <= lo;
					end else begin
						pa_q <= lo;
						pb_q <= hi;
					end
					state_q <= S_DEL_R;
				end
				S_DEL_R: begin
					scan_key_q <= pa_q;
					ph_q       <= PH_PUT_A;
					state_q    <= S_HASH;
				end
				S_RESULT: begin
					if (last_q) begin
						best_q  <= '0;
						full_q  <= 1'b0;
						clr_q   <= '0;
						state_q <= S_CLEAR;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign res_strobe  = (state_q == S_RESULT);
	assign longest_run = best_q;
	assign overflow    = full_q;
	assign done_res    = last_q;

endmodule

// ===== test/tb.sv =====
module tb;

	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [lcrt_pkg::LEN_W-1:0] longest_run;
		logic                       overflow;
		logic                       done_res;
	} run_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] value;
	logic               last;
	logic               res_strobe;
	logic [10:0]        longest_run;
	logic               overflow;
	logic               done_res;

	longest_consecutive_run_tracker dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.value(value), .last(last), .res_strobe(res_strobe),
		.longest_run(longest_run), .overflow(overflow), .done_res(done_res)
	);

	// predictor state
	lcrt_pkg::key_t seen_keys [lcrt_pkg::CAPACITY];
	bit             seen_used [lcrt_pkg::CAPACITY];
	lcrt_pkg::key_t end_keys [lcrt_pkg::CAPACITY];
	lcrt_pkg::key_t end_partners [lcrt_pkg::CAPACITY];
	bit             end_used [lcrt_pkg::CAPACITY];
	int unsigned    best_len;
	bit             table_full;

	run_result_t expected_runs [$];
	int          mismatches;
	int          idle_cycles;
	bit          gaps_on;

	initial clk = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic lcrt_pkg::slot_t probe_slot(lcrt_pkg::key_t k, int unsigned i);
		logic [31:0] h;
		h = k * 32'd2654435761;
		h = h ^ (h >> 16);
		return lcrt_pkg::slot_t'((h % lcrt_pkg::CAPACITY + i) % lcrt_pkg::CAPACITY);
	endfunction

	function automatic int find_end(lcrt_pkg::key_t k);
		lcrt_pkg::slot_t s;
		for (int i = 0; i < lcrt_pkg::PROBE_LIMIT; i++) begin
			s = probe_slot(k, i);
			if (end_used[s] && end_keys[s] == k)
				return int'(s);
		end
		return -1;
	endfunction

	task automatic store_end(lcrt_pkg::key_t k, lcrt_pkg::key_t partner);
		int s;
		lcrt_pkg::slot_t t;
		s = find_end(k);
		if (s < 0) begin
			for (int i = 0; i < lcrt_pkg::PROBE_LIMIT; i++) begin
				t = probe_slot(k, i);
				if (!end_used[t]) begin
					s = int'(t);
					break;
				end
			end
		end
		if (s < 0) begin
			table_full = 1'b1;
			return;
		end
		end_keys[s] = k;
		end_partners[s] = partner;
		end_used[s] = 1'b1;
	endtask

	task automatic drop_end(lcrt_pkg::key_t k);
		int s;
		s = find_end(k);
		if (s >= 0)
			end_used[s] = 1'b0;
	endtask

	task automatic clear_list();
		for (int i = 0; i < lcrt_pkg::CAPACITY; i++) begin
			seen_used[i] = 1'b0;
			end_used[i] = 1'b0;
		end
		best_len = 0;
		table_full = 1'b0;
	endtask

	task automatic absorb_value(lcrt_pkg::key_t v);
		int              free_slot, ls, rs;
		bit              present;
		lcrt_pkg::key_t  lo, hi;
		lcrt_pkg::slot_t s;
		longint unsigned len;
		free_slot = -1;
		present = 1'b0;
		ls = -1;
		rs = -1;
		for (int i = 0; i < lcrt_pkg::PROBE_LIMIT; i++) begin
			s = probe_slot(v, i);
			if (seen_used[s]) begin
				if (seen_keys[s] == v)
					present = 1'b1;
			end else if (free_slot < 0) begin
				free_slot = int'(s);
			end
		end
		if (present)
			return;
		if (free_slot < 0) begin
			table_full = 1'b1;
			return;
		end
		seen_keys[free_slot] = v;
		seen_used[free_slot] = 1'b1;
		if (v != lcrt_pkg::I32_MIN)
			ls = find_end(v - 1);
		if (v != lcrt_pkg::I32_MAX)
			rs = find_end(v + 1);
		if (ls >= 0 && rs >= 0) begin
			lo = end_partners[ls];
			hi = end_partners[rs];
			if (v - 1 != lo)
				drop_end(v - 1);
			if (v + 1 != hi)
				drop_end(v + 1);
			store_end(lo, hi);
			store_end(hi, lo);
		end else if (ls >= 0) begin
			lo = end_partners[ls];
			hi = v;
			if (v - 1 != lo)
				drop_end(v - 1);
			store_end(lo, hi);
			store_end(hi, lo);
		end else if (rs >= 0) begin
			lo = v;
			hi = end_partners[rs];
			if (v + 1 != hi)
				drop_end(v + 1);
			store_end(hi, lo);
			store_end(lo, hi);
		end else begin
			lo = v;
			hi = v;
			store_end(v, v);
		end
		len = longint'(lcrt_pkg::key_t'(hi - lo)) + 1;
		if (len > lcrt_pkg::LEN_MAX)
			len = lcrt_pkg::LEN_MAX;
		if (len > best_len)
			best_len = int'(len);
	endtask

	// send one request and queue its predicted result
	task automatic send_value(lcrt_pkg::key_t v, bit is_last);
		run_result_t r;
		if (gaps_on) begin
			while (busy)
				@(posedge clk);
			while ($urandom_range(99) < 27)
				@(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		last <= is_last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		start <= 1'b0;
		absorb_value(v);
		r.longest_run = best_len[lcrt_pkg::LEN_W-1:0];
		r.overflow = table_full;
		r.done_res = is_last;
		expected_runs.push_back(r);
		if (is_last)
			clear_list();
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		run_result_t e;
		if (res_strobe) begin
			if (expected_runs.size() == 0) begin
				$error("unexpected result: longest_run %0d", longest_run);
				mismatches++;
			end else begin
				e = expected_runs.pop_front();
				if (longest_run !== e.longest_run) begin
					$error("longest_run: expected %0d, got %0d", e.longest_run, longest_run);
					mismatches++;
				end
				if (overflow !== e.overflow) begin
					$error("overflow: expected %0d, got %0d", e.overflow, overflow);
					mismatches++;
				end
				if (done_res !== e.done_res) begin
					$error("done_res: expected %0d, got %0d", e.done_res, done_res);
					mismatches++;
				end
			end
		end
	end

	// watchdog: cycles with no request accepted and no result shown
	always @(posedge clk) begin
		if (res_strobe || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic wait_drained();
		while (expected_runs.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_extremes();
		send_value(32'h7FFF_FFFF, 1'b0);
		send_value(32'h8000_0000, 1'b0);
		send_value(32'h7FFF_FFFE, 1'b0);
		send_value(32'h8000_0001, 1'b0);
		send_value(32'h7FFF_FFFF, 1'b0);   // repeat
		send_value(32'hFFFF_FFFF, 1'b0);
		send_value(32'h0000_0000, 1'b1);
	endtask

	task automatic test_merges();
		// left extend, right extend, merge with single-value neighbours
		send_value(32'd10, 1'b0);
		send_value(32'd12, 1'b0);
		send_value(32'd11, 1'b0);
		send_value(32'd14, 1'b0);
		send_value(32'd13, 1'b0);
		send_value(32'd9, 1'b0);
		send_value(32'd20, 1'b0);
		send_value(32'd22, 1'b0);
		send_value(32'd21, 1'b0);
		send_value(32'd15, 1'b0);
		send_value(32'd12, 1'b1);
	endtask

	task automatic test_overflow();
		// values that all hash to one slot fill its probe window
		lcrt_pkg::key_t v;
		int             n;
		n = 0;
		v = 32'd0;
		while (n < lcrt_pkg::PROBE_LIMIT + 2) begin
			if (probe_slot(v, 0) == probe_slot(32'd0, 0)) begin
				send_value(v, 1'b0);
				n++;
			end
			v = v + 32'd7;
		end
		send_value(32'd1, 1'b1);
	endtask

	task automatic test_random_lists();
		lcrt_pkg::key_t base;
		int             len, cnt;
		cnt = 0;
		while (cnt < 1000) begin
			gaps_on = !(cnt >= 400 && cnt < 550);
			len = $urandom_range(40, 1);
			base = $urandom();
			for (int i = 0; i < len; i++) begin
				case ($urandom_range(9))
					0: send_value($urandom(), i == len - 1);
					1: send_value(32'h7FFF_FFFF - $urandom_range(8), i == len - 1);
					2: send_value(32'h8000_0000 + $urandom_range(8), i == len - 1);
					default: send_value(base + $urandom_range(48), i == len - 1);
				endcase
				cnt++;
			end
			if (cnt > 700 && cnt < 760)
				wait_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		last = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		gaps_on = 1'b1;
		clear_list();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_extremes();
		test_merges();
		test_overflow();
		test_random_lists();
		wait_drained();
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/lcrt_pkg.sv
rtl/lcrt_ram.sv
rtl/lcrt_hash.sv
rtl/longest_consecutive_run_tracker.sv
test/tb.sv
